// File: design/qpht_pkg.sv
package qpht_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 48;
  localparam int LEN_W   = 32;
  localparam int RND_W   = 33;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int LIMIT_W = 9;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 9'd128;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 9'd511;

  // operation codes (code 3 is not an operation and answers invalid)
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_FULL        = 3'd2,
    ST_INVALID     = 3'd3,
    ST_PROBE_LIMIT = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic hash;
    logic read;
    logic check;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic early;
    logic home_done;
    logic probe_done;
  } sts_t;

endpackage

// File: design/qpht_if.sv
interface qpht_req_if;
  import qpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    key_address;
  logic [LEN_W-1:0]    byte_length;

  modport source (output valid, kind, key_address, byte_length, input ready);
  modport sink   (input valid, kind, key_address, byte_length, output ready);
endinterface

interface qpht_rsp_if;
  import qpht_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [LEN_W-1:0]    found_length;
  logic [RND_W-1:0]    rounded_length;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_length, rounded_length, slot_index,
                  entry_count, input ready);
  modport sink   (input valid, status, found_length, rounded_length, slot_index,
                  entry_count, output ready);
endinterface

// File: design/qpht_ram.sv
module qpht_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/qpht_ctrl.sv
module qpht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output qpht_pkg::cmd_t cmd,
  input  qpht_pkg::sts_t sts
);
  import qpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        priority if (sts.early) state_next = S_FINISH;
        else if (sts.home_done) state_next = S_READ;
        else state_next = S_HASH;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.probe_done ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/qpht_dp.sv
module qpht_dp #(
  parameter int TABLE_SLOTS = 256,
  parameter int PAGE_SHIFT  = 12,
  parameter int PROBE_LIMIT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qpht_pkg::cmd_t                 cmd,
  output qpht_pkg::sts_t                 sts,
  input  logic                           cfg_wen,
  input  logic [qpht_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic [qpht_pkg::KIND_W-1:0]    kind,
  input  logic [qpht_pkg::KEY_W-1:0]     key_address,
  input  logic [qpht_pkg::LEN_W-1:0]     byte_length,
  output qpht_pkg::status_t              status,
  output logic [qpht_pkg::LEN_W-1:0]     found_length,
  output logic [qpht_pkg::RND_W-1:0]     rounded_length,
  output logic [qpht_pkg::SLOT_W-1:0]    slot_index,
  output logic [qpht_pkg::COUNT_W-1:0]   entry_count
);
  import qpht_pkg::*;

  localparam int S      = $clog2(TABLE_SLOTS);
  localparam int PW     = $clog2(PROBE_LIMIT + 1);
  localparam int ENT_W  = KEY_W + LEN_W;
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [S:0]    SLOTS   = (S+1)'(TABLE_SLOTS);
  localparam logic [S-1:0]  LAST    = S'(TABLE_SLOTS - 1);
  localparam logic [PW-1:0] P_LIMIT = PW'(PROBE_LIMIT);

  function automatic logic [S-1:0] mod_add(input logic [S-1:0] a, input logic [S-1:0] b);
    logic [S:0] t;
    t = {1'b0, a} + {1'b0, b};
    return (t >= SLOTS) ? S'(t - SLOTS) : S'(t);
  endfunction

  // captured item
  logic [KIND_W-1:0]  kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [LEN_W-1:0]   len_r;
  logic [RND_W-1:0]   rnd_r;

  // control state
  logic [S-1:0]       clr_idx;
  logic [COUNT_W-1:0] count;
  logic [LIMIT_W-1:0] load_limit;

  // probe walk
  logic [S-1:0]  idx;
  logic [S-1:0]  inc;
  logic [S-1:0]  odd;
  logic [PW-1:0] p;
  logic [PW-1:0] p_next;

  // working result
  status_t           res_status;
  logic [LEN_W-1:0]  res_found;
  logic [SLOT_W-1:0] res_slot;

  logic [S-1:0]  home;
  logic          home_done;

  logic             ram_we;
  logic [S-1:0]     ram_addr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  logic [KEY_W-1:0] ent_key;
  logic [LEN_W-1:0] ent_len;
  logic is_ins, is_rem, invalid, full;
  logic ins_take, match, miss_end, last_probe;
  logic [RND_W-1:0] rnd_sum;

  // rounding up to 16 bytes, minimum 16
  assign rnd_sum = ({1'b0, byte_length} + RND_W'(15)) & ~RND_W'(15);

  // home slot
  generate
    if (IS_POW2) begin : g_home_mask
      assign home      = key_r[PAGE_SHIFT +: S];
      assign home_done = 1'b1;
    end else begin : g_home_fold
      // page number folded in one byte per cycle, most significant first:
      // rem = (rem * 256 + byte) mod TABLE_SLOTS, quotient by reciprocal multiply
      localparam int KW = KEY_W - PAGE_SHIFT;
      localparam int NB = (KW + 7) / 8;
      localparam int CW = $clog2(NB + 1);
      localparam int YW = S + 8;
      localparam int MW = 9;
      localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / TABLE_SLOTS);
      localparam logic [YW-1:0] N_Y   = YW'(TABLE_SLOTS);
      logic [NB*8-1:0]  shreg;
      logic [S-1:0]     rem;
      logic [CW-1:0]    cnt;
      logic [YW-1:0]    y;
      logic [YW+MW-1:0] prod;
      logic [7:0]       q_est;
      logic [YW-1:0]    qn;
      logic [YW-1:0]    r0;
      logic [S-1:0]     rem_next;

      // estimate is the true quotient or one below, so one correction step
      assign y        = {rem, shreg[NB*8-1 -: 8]};
      assign prod     = y * RECIP;
      assign q_est    = prod[YW +: 8];
      assign qn       = q_est * N_Y;
      assign r0       = y - qn;
      assign rem_next = (r0 >= N_Y) ? S'(r0 - N_Y) : S'(r0);

      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (cmd.capture) begin
          cnt <= CW'(NB);
        end else if (cnt != '0) begin
          cnt <= cnt - CW'(1);
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          shreg <= (NB*8)'(key_address >> PAGE_SHIFT);
          rem   <= '0;
        end else if (cnt != '0) begin
          shreg <= shreg << 8;
          rem   <= rem_next;
        end
      end

      assign home      = rem;
      assign home_done = (cnt == '0);
    end
  endgenerate

  // early answers
  assign is_ins  = (kind_r == KIND_INSERT);
  assign is_rem  = (kind_r == KIND_REMOVE);
  assign invalid = (key_r == '0) ||
                   !(kind_r == KIND_INSERT || kind_r == KIND_REMOVE || kind_r == KIND_LOOKUP);
  assign full    = is_ins && ((count > load_limit) || (count == COUNT_MAX));

  // slot examination
  assign ent_key    = ram_rdata[ENT_W-1 -: KEY_W];
  assign ent_len    = ram_rdata[LEN_W-1:0];
  assign p_next     = p + PW'(1);
  assign ins_take   = is_ins && (ent_key == '0);
  assign match      = !is_ins && (ent_key == key_r);
  assign miss_end   = !is_ins && !match && (ent_len == '0);
  assign last_probe = (p_next == P_LIMIT);

  assign sts.clr_last   = (clr_idx == LAST);
  assign sts.early      = invalid || full;
  assign sts.home_done  = home_done;
  assign sts.probe_done = ins_take || match || miss_end || last_probe;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = {key_r, len_r};
    priority if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_idx;
      ram_wdata = '0;
    end else if (cmd.check && ins_take) begin
      ram_we = 1'b1;
    end else if (cmd.check && match && is_rem) begin
      ram_we    = 1'b1;
      ram_wdata = {{KEY_W{1'b0}}, ent_len};
    end
  end

  qpht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      count      <= '0;
      load_limit <= LOAD_LIMIT_RESET;
    end else begin
      if (cfg_wen) load_limit <= cfg_wdata;
      if (cmd.clear) clr_idx <= sts.clr_last ? '0 : clr_idx + S'(1);
      if (cmd.check && ins_take) begin
        count <= count + COUNT_W'(1);
      end else if (cmd.check && match && is_rem && count != '0) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= kind;
      key_r      <= key_address;
      len_r      <= byte_length;
      rnd_r      <= (kind != KIND_INSERT) ? '0 :
                    (rnd_sum == '0) ? RND_W'(16) : rnd_sum;
      res_found  <= '0;
      res_slot   <= '0;
      res_status <= ST_INVALID;
    end

    // early items take their status; else home slot reloaded every hash cycle, the last leaves the final value
    if (cmd.hash) begin
      priority if (invalid) begin
        res_status <= ST_INVALID;
      end else if (full) begin
        res_status <= ST_FULL;
      end else begin
        idx <= home;
        inc <= S'(1);
        odd <= S'(3);
        p   <= '0;
      end
    end

    if (cmd.check) begin
      priority if (ins_take || match) begin
        res_status <= ST_OK;
        res_slot   <= SLOT_W'(idx);
        if (!is_ins && !is_rem) res_found <= ent_len;
      end else if (miss_end) begin
        res_status <= ST_NOT_FOUND;
      end else if (last_probe) begin
        res_status <= ST_PROBE_LIMIT;
      end else begin
        idx <= mod_add(idx, inc);
        inc <= mod_add(inc, odd);
        odd <= mod_add(odd, S'(2));
        p   <= p_next;
      end
    end

    if (cmd.load_out) begin
      status         <= res_status;
      found_length   <= res_found;
      rounded_length <= rnd_r;
      slot_index     <= res_slot;
      entry_count    <= count;
    end
  end

endmodule

// File: design/quadratic_probe_hash_table_core.sv
// channel   dir   handshake        payload
// req       in    valid / ready    kind, key_address, byte_length
// rsp       out   valid / ready    status, found_length, rounded_length, slot_index,
//                                  entry_count
// cfg       in    cfg_wen          cfg_wdata (load_limit)
//
// one item at a time: accept, hash, then for each slot probed a memory read, then a check
// and optional write on the single memory port, then a load of the output register
// a zero key, unused kind or full table skips the probe loop and goes from hash
// to the output register
// other table sizes stay in hash while the page number is folded, byte by byte,
// into the home-slot remainder
// after reset a clearing pass writes every slot with req.ready low
// a stalled rsp holds the finished item; the next item is worked on up to its result
module quadratic_probe_hash_table_core #(
  parameter int TABLE_SLOTS = 256,
  parameter int PAGE_SHIFT  = 12,
  parameter int PROBE_LIMIT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  qpht_req_if.sink                      req,
  qpht_rsp_if.source                    rsp,
  input  logic                          cfg_wen,
  input  logic [qpht_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import qpht_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // sequencer: clearing pass, hash, probe loop, result hand-off
  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memory, probe arithmetic, live count and output register
  qpht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .kind           (req.kind),
    .key_address    (req.key_address),
    .byte_length    (req.byte_length),
    .status         (rsp.status),
    .found_length   (rsp.found_length),
    .rounded_length (rsp.rounded_length),
    .slot_index     (rsp.slot_index),
    .entry_count    (rsp.entry_count)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // only one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while another in flight");

  // a failed operation reports no slot
  a_slot_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.slot_index == '0)
    else $error("slot reported on failed operation");

  // a length comes back only on success
  a_found_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.found_length == '0)
    else $error("length reported on failed operation");

  // rounded length is a multiple of 16
  a_rounded: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.rounded_length[3:0] == 4'd0)
    else $error("rounded length not 16-byte aligned");

endmodule

// File: tb/tb_quadratic_probe_hash_table_core.sv
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table_core;
  import qpht_pkg::*;

  localparam int TABLE_SLOTS = 256;
  localparam int PAGE_SHIFT  = 12;
  localparam int PROBE_LIMIT = 256;

  // worst item, plus stalls on both sides, taken several times over
  localparam int CYCLE_LIMIT  = 3000000;
  // quiet time after the last answer, a little over the slowest item
  localparam int SETTLE_CYCLES = 600;

  // kind code 3 is not an operation; the block answers it as invalid
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one expected answer
  typedef struct {
    status_t            status;
    logic [LEN_W-1:0]   found_length;
    logic [RND_W-1:0]   rounded_length;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] entry_count;
  } op_outcome_t;

  // shadow copy of the allocation table, with the answers still owed by the block
  class alloc_table_tracker;
    logic [KEY_W-1:0]   keys [TABLE_SLOTS];
    logic [LEN_W-1:0]   lens [TABLE_SLOTS];
    logic [COUNT_W-1:0] live;
    logic [LIMIT_W-1:0] limit;
    op_outcome_t        awaited [$];
    int                 mismatches;
    int                 status_hits [5];

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        keys[i] = '0;
        lens[i] = '0;
      end
      live = '0;
      limit = LOAD_LIMIT_RESET;
      mismatches = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // works out the answer to one accepted item and updates the shadow table
    function void note_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                          logic [LEN_W-1:0] len);
      op_outcome_t       o;
      logic [SLOT_W-1:0] idx;
      logic [RND_W-1:0]  rnd;
      logic [31:0]       sq;
      bit                done;
      o.status         = ST_INVALID;
      o.found_length   = '0;
      o.rounded_length = '0;
      o.slot_index     = '0;
      done = 1'b0;
      if (kind == KIND_INSERT) begin
        rnd = {1'b0, len} + 33'd15;
        rnd[3:0] = '0;
        o.rounded_length = (rnd < 33'd16) ? 33'd16 : rnd;
      end
      // home slot: page number modulo a power-of-two table
      idx = key[PAGE_SHIFT +: SLOT_W];
      if (key != '0 && kind == KIND_INSERT) begin
        if (live > limit || live >= COUNT_MAX) begin
          o.status = ST_FULL;
        end else begin
          o.status = ST_PROBE_LIMIT;
          for (int p = 0; p < PROBE_LIMIT && !done; p++) begin
            if (keys[idx] == '0) begin
              keys[idx] = key;
              lens[idx] = len;
              live = live + 1'b1;
              o.status = ST_OK;
              o.slot_index = idx;
              done = 1'b1;
            end else begin
              sq = (p + 1) * (p + 1);
              idx = idx + sq[SLOT_W-1:0];
            end
          end
        end
      end else if (key != '0 && (kind == KIND_REMOVE || kind == KIND_LOOKUP)) begin
        o.status = ST_PROBE_LIMIT;
        for (int p = 0; p < PROBE_LIMIT && !done; p++) begin
          if (keys[idx] == key) begin
            o.status = ST_OK;
            o.slot_index = idx;
            if (kind == KIND_REMOVE) begin
              keys[idx] = '0;
              if (live > 0) live = live - 1'b1;
            end else begin
              o.found_length = lens[idx];
            end
            done = 1'b1;
          end else if (lens[idx] == '0) begin
            o.status = ST_NOT_FOUND;
            done = 1'b1;
          end else begin
            sq = (p + 1) * (p + 1);
            idx = idx + sq[SLOT_W-1:0];
          end
        end
      end
      o.entry_count = live;
      awaited.push_back(o);
    endfunction

    function void field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compares one accepted answer with the oldest one owed
    function void check_answer(status_t st, logic [LEN_W-1:0] fl, logic [RND_W-1:0] rl,
                               logic [SLOT_W-1:0] si, logic [COUNT_W-1:0] ec);
      op_outcome_t w;
      if (awaited.size() == 0) begin
        $display("%0t: answer with none owed, expected nothing actual status %0h",
                 $time, st);
        mismatches++;
        return;
      end
      w = awaited.pop_front();
      if (!$isunknown(st) && st <= ST_PROBE_LIMIT) status_hits[int'(st)]++;
      field_diff("status", w.status, st);
      field_diff("found_length", w.found_length, fl);
      field_diff("rounded_length", w.rounded_length, rl);
      field_diff("slot_index", w.slot_index, si);
      field_diff("entry_count", w.entry_count, ec);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic [LIMIT_W-1:0]  cfg_wdata;

  qpht_req_if req_ch ();
  qpht_rsp_if rsp_ch ();

  quadratic_probe_hash_table_core #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .PAGE_SHIFT (PAGE_SHIFT),
    .PROBE_LIMIT(PROBE_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  alloc_table_tracker board;

  bit               idle_on = 1'b1;   // random gaps and stalls, off for the last part
  logic [KEY_W-1:0] key_pool [$];     // keys offered to insert, reused for remove, lookup and repeat inserts
  int               items_sent = 0;
  int               limits_used = 1;  // the reset value counts as one setting
  int               cycle_count = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still owed", cycle_count,
               board.awaited.size());
      $display("quadratic_probe_hash_table_core: mismatch");
      $finish;
    end
  end

  // answer side: ready changes at the falling edge, stalls come in short bursts
  initial begin
    int stall;
    int quiet;
    rsp_ch.ready = 1'b0;
    stall = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (quiet > 0) begin
        quiet--;
      end else if (idle_on && stall == 0) begin
        if ($urandom_range(0, 199) == 0) quiet = $urandom_range(50, 200);
        else if ($urandom_range(0, 4) == 0) stall = $urandom_range(1, 7);
      end
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // every accepted answer is checked at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      board.check_answer(rsp_ch.status, rsp_ch.found_length, rsp_ch.rounded_length,
                         rsp_ch.slot_index, rsp_ch.entry_count);
  end

  // offers one item, with an optional gap first; returns at the accepting edge
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [LEN_W-1:0] len);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid       = 1'b1;
    req_ch.kind        = kind;
    req_ch.key_address = key;
    req_ch.byte_length = len;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_op(kind, key, len);
    items_sent++;
  endtask

  // sender holds off until every owed answer has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_load_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    board.limit = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    limits_used++;
  endtask

  // many keys crowd onto eight home slots so that probe chains grow
  function automatic logic [KEY_W-1:0] pick_key(logic [KIND_W-1:0] kind);
    logic [63:0]       raw;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] home;
    int                r;
    raw = {$urandom, $urandom};
    k = raw[KEY_W-1:0];
    r = $urandom_range(0, 99);
    if (r < 2) begin
      k = '0;
    end else if (r < 40 || (r < (kind == KIND_INSERT ? 48 : 80) && key_pool.size() == 0)) begin
      home = SLOT_W'($urandom_range(0, 7));
      k[PAGE_SHIFT +: SLOT_W] = home * 8'd29;
    end else if (r < (kind == KIND_INSERT ? 48 : 80)) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return LEN_W'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  // random items; lookup takes whatever share insert, remove and the unused code leave
  task automatic run_phase(input int count, input int w_ins, input int w_rem);
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    int                r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) kind = KIND_UNUSED;
      else if (r < 2 + w_ins) kind = KIND_INSERT;
      else if (r < 2 + w_ins + w_rem) kind = KIND_REMOVE;
      else kind = KIND_LOOKUP;
      key = pick_key(kind);
      send_op(kind, key, pick_length());
      if (kind == KIND_INSERT && key != '0) begin
        key_pool.push_back(key);
        if (key_pool.size() > 256) void'(key_pool.pop_front());
      end
    end
  endtask

  // hand-picked items under the reset load limit
  task automatic run_directed();
    send_op(KIND_LOOKUP, 48'h0000_0000_5000, 32'd0);          // empty table, search ends at once
    send_op(KIND_INSERT, 48'h0, 32'd100);                     // zero key on every kind
    send_op(KIND_REMOVE, 48'h0, 32'd0);
    send_op(KIND_LOOKUP, 48'h0, 32'd0);
    send_op(KIND_UNUSED, 48'h0000_0000_5000, 32'd7);          // unused kind code
    send_op(KIND_INSERT, 48'h0000_0000_5000, 32'd1);          // rounds up to the minimum
    send_op(KIND_INSERT, 48'h0000_0010_5000, 32'd16);         // same home, first probe step
    send_op(KIND_INSERT, 48'h0000_0020_5000, 32'hFFFF_FFFF);  // longest length, widest rounding
    send_op(KIND_INSERT, 48'hFFFF_FFFF_FFFF, 32'd17);         // all-ones key, last slot
    send_op(KIND_LOOKUP, 48'h0000_0020_5000, 32'd0);          // hit along the chain
    send_op(KIND_REMOVE, 48'h0000_0010_5000, 32'd0);          // leaves a tombstone
    send_op(KIND_LOOKUP, 48'h0000_0020_5000, 32'd0);          // search passes the tombstone
    send_op(KIND_LOOKUP, 48'h0000_0010_5000, 32'd0);          // removed key is gone
    send_op(KIND_INSERT, 48'h0000_0030_5000, 32'h20);         // insert reuses the tombstone
    send_op(KIND_INSERT, 48'h0000_0000_5000, 32'd8);          // duplicate key gets a second record
    send_op(KIND_REMOVE, 48'h0000_0000_5000, 32'd0);          // removes the first of the two
    send_op(KIND_LOOKUP, 48'h0000_0000_5000, 32'd0);          // finds the second
    send_op(KIND_INSERT, 48'h0000_0000_9000, 32'd0);          // live record of length zero
    send_op(KIND_LOOKUP, 48'h0000_0010_9000, 32'd0);          // stops at it, not found
    send_op(KIND_LOOKUP, 48'h0000_0000_9000, 32'd0);          // its own key still hits
    send_op(KIND_REMOVE, 48'h0000_0000_9000, 32'd0);          // slot goes back to never used
    send_op(KIND_INSERT, 48'hAAAA_AAAA_A000, 32'hAAAA_AAAA);  // alternating bit patterns
    send_op(KIND_INSERT, 48'h5555_5555_5FFF, 32'h5555_5555);
    send_op(KIND_LOOKUP, 48'h5555_5555_5FFF, 32'd0);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_wen            = 1'b0;
    cfg_wdata          = LOAD_LIMIT_RESET;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_INSERT;
    req_ch.key_address = '0;
    req_ch.byte_length = '0;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // the clearing pass after reset is covered by the request handshake
    run_directed();
    drain();

    // highest limit: mostly inserts, the table crowds and probes run out
    set_load_limit(9'd256);
    run_phase(300, 70, 8);
    drain();

    // lowest limit: inserts refused while the table is crowded
    set_load_limit(9'd1);
    run_phase(150, 25, 45);
    drain();

    // random limit, with the sender pausing halfway until all answers are in
    set_load_limit(LIMIT_W'($urandom_range(1, 256)));
    run_phase(125, 35, 35);
    drain();
    run_phase(125, 35, 35);
    drain();

    // mostly removes to thin the table out again
    set_load_limit(9'd64);
    run_phase(200, 20, 50);
    drain();

    // last part at full rate, no gaps and no stalls
    idle_on = 1'b0;
    set_load_limit(9'd200);
    run_phase(100, 40, 30);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items under %0d load limit settings",
             items_sent, limits_used);
    $display("answers: ok %0d, not found %0d, full %0d, invalid %0d, probe limit %0d",
             board.status_hits[0], board.status_hits[1], board.status_hits[2],
             board.status_hits[3], board.status_hits[4]);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("quadratic_probe_hash_table_core: match");
    end else begin
      $display("quadratic_probe_hash_table_core: mismatch");
    end
    $finish;
  end

endmodule
